@@ rtl/pat_pkg.sv @@
// Shared types, constants and helpers for the peer address table.
package pat_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ENTRIES);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int SLOT_W = 4;

   localparam logic [1:0] MODE_UPSERT  = 2'd0;
   localparam logic [1:0] MODE_RESOLVE = 2'd1;
   localparam logic [1:0] MODE_PURGE   = 2'd2;

   localparam logic [62:0] TIME_MAX = '1;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_UPSERT,
      OP_RESOLVE,
      OP_PURGE
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] node_id;
      logic [47:0] peer_mac_in;
      logic [62:0] now_us;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [47:0] peer_mac_out;
      logic        store_request;
      logic [3:0]  slot_used;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] node_id;
      logic [47:0] mac;
      logic [62:0] now_us;
   } cmd_type;

   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage

@@ rtl/pat_front.sv @@
// Request intake: decode the mode and queue commands for the table sequencer.
module pat_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pat_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output pat_pkg::cmd_type cmd
);
   import pat_pkg::*;

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   op_type            op;
   logic              push;
   logic              pop;

   always_comb begin
      unique case (req_data.mode)
         MODE_UPSERT:  op = OP_UPSERT;
         MODE_RESOLVE: op = OP_RESOLVE;
         MODE_PURGE:   op = OP_PURGE;
         default:      op = OP_NONE;
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_pop;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{op: op, node_id: req_data.node_id,
                                  mac: req_data.peer_mac_in, now_us: req_data.now_us};
      end
   end

endmodule

@@ rtl/pat_back.sv @@
// Table storage and scan sequencer: match, victim choice, purge and result register.
module pat_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  pat_pkg::cmd_type cmd,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [62:0]      csr_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pat_pkg::rsp_type rsp_data
);
   import pat_pkg::*;

   logic [31:0] node_mem [ENTRIES];
   logic [47:0] mac_mem  [ENTRIES];
   logic [62:0] time_mem [ENTRIES];

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [IDX_W-1:0]  ev_idx_ff;
   logic [31:0]       rd_node_ff;
   logic [47:0]       rd_mac_ff;
   logic [62:0]       rd_time_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [62:0]       max_age_ff;

   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [47:0]       hit_mac_ff;
   logic              inv_ff;
   logic [IDX_W-1:0]  inv_idx_ff;
   logic [IDX_W-1:0]  old_idx_ff;
   logic [62:0]       old_time_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           result;

   logic [IDX_W-1:0]  rd_addr;
   logic              evaluate;
   logic              take;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic              ent_valid;
   logic              match;
   logic [62:0]       age;
   logic              stale;

   assign csr_ready = 1'b1;
   assign rd_addr   = cnt_ff[IDX_W-1:0];
   assign ent_valid = valid_ff[ev_idx_ff];
   assign match     = ent_valid && (rd_node_ff == cmd.node_id);
   assign age       = cmd.now_us - rd_time_ff;
   assign stale     = ent_valid && (cmd.now_us > rd_time_ff) && (age > max_age_ff);
   assign wr_idx    = hit_ff ? hit_idx_ff : (inv_ff ? inv_idx_ff : old_idx_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == SCAN_END) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      evaluate = 1'b0;
      take     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   ;
         ST_SCAN:   evaluate = (cnt_ff != '0);
         ST_FINISH: take = !rsp_valid_ff || !rsp_stall;
         default:   ;
      endcase
   end

   assign cmd_pop = take;
   assign wr_en   = take && (cmd.op == OP_UPSERT);

   always_comb begin
      result = '0;
      unique case (cmd.op)
         OP_UPSERT: begin
            result.store_request = !hit_ff || (hit_mac_ff != cmd.mac);
            result.slot_used     = to_slot(wr_idx);
         end
         OP_RESOLVE: begin
            if (hit_ff) begin
               result.found        = 1'b1;
               result.peer_mac_out = hit_mac_ff;
               result.slot_used    = to_slot(hit_idx_ff);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (evaluate && (cmd.op == OP_PURGE) && stale) begin
         valid_in[ev_idx_ff] = 1'b0;
      end
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         max_age_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_age_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         cnt_ff      <= '0;
         hit_ff      <= 1'b0;
         inv_ff      <= 1'b0;
         old_idx_ff  <= '0;
         old_time_ff <= TIME_MAX;
      end else if (state_ff == ST_SCAN) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      ev_idx_ff <= rd_addr;
      if (evaluate) begin
         if (match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= ev_idx_ff;
            hit_mac_ff <= rd_mac_ff;
         end
         if (!ent_valid && !inv_ff) begin
            inv_ff     <= 1'b1;
            inv_idx_ff <= ev_idx_ff;
         end
         if (ent_valid && (rd_time_ff < old_time_ff)) begin
            old_time_ff <= rd_time_ff;
            old_idx_ff  <= ev_idx_ff;
         end
      end
      if (take) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      rd_node_ff <= node_mem[rd_addr];
      rd_mac_ff  <= mac_mem[rd_addr];
      rd_time_ff <= time_mem[rd_addr];
      if (wr_en) begin
         node_mem[wr_idx] <= cmd.node_id;
         mac_mem[wr_idx]  <= cmd.mac;
         time_mem[wr_idx] <= cmd.now_us;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/peer_address_table.sv @@
// Top level of the peer address table: intake queue plus table sequencer.
//
// Request channel (req_valid, req_stall, req_data): a request is taken at a
// clock edge with req_valid high and req_stall low. Modes: upsert a peer,
// resolve a node id, purge entries older than max_age, or an unused code
// that answers with an all-zero response and changes nothing.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one response
// per request, in request order.
// Configuration (csr_valid, csr_ready, csr_data): writes max_age; csr_ready
// is always high. Write it only while no request is in flight.
// The sequencer works on one request at a time and takes the next only after
// the previous result is registered. The sequencer reads the table memory
// one entry per cycle through a single registered read port.
// A two-deep queue lets new requests enter while the sequencer works.
// Reset clears all entry valid bits, max_age and both channels' state.
// A stalled response holds its value; the sequencer waits on it and the
// queue fills, then req_stall rises.
module peer_address_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pat_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [62:0]      csr_data
);
   import pat_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   pat_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   pat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/pat_checker.sv @@
// Port-level assertions for the peer address table and their bind.
module pat_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pat_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.peer_mac_out == 48'd0)
      else $error("nonzero address without a hit");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.found && rsp_data.store_request))
      else $error("hit and store request together");

endmodule

bind peer_address_table pat_checker u_pat_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ verif/peer_address_table_tb.sv @@
// Self-checking testbench for peer_address_table: directed and random requests against a predictor or fixed responses.
module peer_address_table_tb;
   import pat_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic CHECK_TYPED = 1'b1;
   localparam logic CHECK_MODEL = 1'b0;
   localparam logic [31:0] ONES32 = 32'hFFFF_FFFF;
   localparam logic [47:0] ONES48 = 48'hFFFF_FFFF_FFFF;
   localparam int DRAIN_CYCLES = ENTRIES + 8;
   localparam int LIMIT_CYCLES = 400_000;
   localparam int PHASES = 5;
   localparam int PHASE_ITEMS = 100;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      req_type    req;
      logic       typed;
      rsp_type    rsp;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 20;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      {MODE_RESOLVE, 32'h0, 48'h0, 63'h0, CHECK_TYPED, 1'b0, 48'h0, 1'b0, 4'd0},
      {MODE_RESOLVE, ONES32, 48'h0, 63'h0, CHECK_TYPED, 1'b0, 48'h0, 1'b0, 4'd0},
      {MODE_PURGE, 32'h0, 48'h0, TIME_MAX, CHECK_TYPED, 1'b0, 48'h0, 1'b0, 4'd0},
      {MODE_UNUSED, ONES32, ONES48, TIME_MAX, CHECK_TYPED, 1'b0, 48'h0, 1'b0, 4'd0},
      {MODE_UPSERT, 32'h0, 48'h0, 63'h0, CHECK_TYPED, 1'b0, 48'h0, 1'b1, 4'd0},
      {MODE_UPSERT, ONES32, ONES48, TIME_MAX, CHECK_TYPED, 1'b0, 48'h0, 1'b1, 4'd1},
      {MODE_UPSERT, ONES32, ONES48, TIME_MAX, CHECK_TYPED, 1'b0, 48'h0, 1'b0, 4'd1},
      {MODE_RESOLVE, ONES32, 48'h0, 63'h0, CHECK_TYPED, 1'b1, ONES48, 1'b0, 4'd1},
      {MODE_RESOLVE, 32'h0, 48'h0, 63'h0, CHECK_TYPED, 1'b1, 48'h0, 1'b0, 4'd0},
      {MODE_UPSERT, 32'h0, 48'h0123_4567_89AB, 63'd100,
       CHECK_TYPED, 1'b0, 48'h0, 1'b1, 4'd0},
      {MODE_UPSERT, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 63'd50,
       CHECK_TYPED, 1'b0, 48'h0, 1'b1, 4'd2},
      {MODE_UPSERT, 32'hAAAA_AAAA, 48'h5555_5555_5555, 63'd50,
       CHECK_TYPED, 1'b0, 48'h0, 1'b1, 4'd3},
      {MODE_PURGE, 32'h0, 48'h0, 63'd60, CHECK_MODEL, 54'h0},
      {MODE_RESOLVE, 32'h5555_5555, 48'h0, 63'h0, CHECK_MODEL, 54'h0},
      {MODE_RESOLVE, 32'h0, 48'h0, 63'h0, CHECK_MODEL, 54'h0},
      {MODE_UPSERT, 32'h1234_5678, 48'h0000_BEEF_0001, 63'd60, CHECK_MODEL, 54'h0},
      {MODE_PURGE, 32'h0, 48'h0, 63'd100, CHECK_MODEL, 54'h0},
      {MODE_RESOLVE, 32'h1234_5678, 48'h0, 63'h0, CHECK_MODEL, 54'h0},
      {MODE_RESOLVE, ONES32, 48'h0, 63'h0, CHECK_MODEL, 54'h0},
      {MODE_UNUSED, 32'h1234_5678, 48'h1, 63'd1, CHECK_TYPED, 1'b0, 48'h0, 1'b0, 4'd0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [62:0] csr_data = '0;

   // predictor state
   logic        tbl_valid [ENTRIES];
   logic [31:0] tbl_node [ENTRIES];
   logic [47:0] tbl_mac [ENTRIES];
   logic [62:0] tbl_seen [ENTRIES];
   logic [62:0] age_limit;

   rsp_type expected_rsp [$];
   int      idle_pct = 14;
   int      error_count = 0;
   int      responses_seen = 0;
   int      n_requests = 0;
   int      n_upserts = 0;
   int      n_stores = 0;
   int      n_evictions = 0;
   int      n_resolves = 0;
   int      n_hits = 0;
   int      n_purges = 0;
   int      n_purged = 0;
   int      n_unused = 0;
   int      n_settings = 0;

   peer_address_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("peer_address_table_tb NOT OK");
      $finish;
   end

   function automatic logic [62:0] rand63();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[62:0];
   endfunction

   function automatic logic [47:0] rand48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   function automatic int find_peer(input logic [31:0] id);
      int hit;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && tbl_valid[i] && tbl_node[i] == id) hit = i;
      end
      return hit;
   endfunction

   function automatic rsp_type predict_table_response(input req_type r);
      rsp_type     res;
      int          hit;
      logic        changed;
      logic [62:0] oldest;
      res = '0;
      case (r.mode)
         MODE_UPSERT: begin
            hit = find_peer(r.node_id);
            changed = 1'b0;
            if (hit < 0) begin
               changed = 1'b1;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit < 0 && !tbl_valid[i]) hit = i;
               end
               if (hit < 0) begin
                  n_evictions++;
                  hit = 0;
                  oldest = TIME_MAX;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (tbl_seen[i] < oldest) begin
                        oldest = tbl_seen[i];
                        hit = i;
                     end
                  end
               end
            end else if (tbl_mac[hit] != r.peer_mac_in) begin
               changed = 1'b1;
            end
            tbl_node[hit] = r.node_id;
            tbl_mac[hit] = r.peer_mac_in;
            tbl_seen[hit] = r.now_us;
            tbl_valid[hit] = 1'b1;
            res.store_request = changed;
            res.slot_used = hit[3:0];
         end
         MODE_RESOLVE: begin
            hit = find_peer(r.node_id);
            if (hit >= 0) begin
               res.found = 1'b1;
               res.peer_mac_out = tbl_mac[hit];
               res.slot_used = hit[3:0];
            end
         end
         MODE_PURGE: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_valid[i] && r.now_us > tbl_seen[i]
                   && (r.now_us - tbl_seen[i]) > age_limit) begin
                  tbl_valid[i] = 1'b0;
                  n_purged++;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endtask

   task automatic send_request(input req_type r, input logic typed, input rsp_type typed_rsp);
      rsp_type res;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = predict_table_response(r);
      if (typed) res = typed_rsp;
      expected_rsp.push_back(res);
      n_requests++;
      case (r.mode)
         MODE_UPSERT: begin
            n_upserts++;
            if (res.store_request) n_stores++;
         end
         MODE_RESOLVE: begin
            n_resolves++;
            if (res.found) n_hits++;
         end
         MODE_PURGE: n_purges++;
         default: n_unused++;
      endcase
   endtask

   // hold off until every response is back and the sequencer has gone quiet
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_max_age(input logic [62:0] value);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      age_limit = value;
      n_settings++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (expected_rsp.size() == 0) begin
               report_error($sformatf("unexpected response %0d: %h", responses_seen, rsp_data));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.found !== want.found
                   || rsp_data.peer_mac_out !== want.peer_mac_out
                   || rsp_data.store_request !== want.store_request
                   || rsp_data.slot_used !== want.slot_used) begin
                  report_error($sformatf(
                     "response %0d: expected found=%0b mac=%h store=%0b slot=%0d, %s",
                     responses_seen, want.found, want.peer_mac_out, want.store_request,
                     want.slot_used,
                     $sformatf("got found=%0b mac=%h store=%0b slot=%0d",
                        rsp_data.found, rsp_data.peer_mac_out, rsp_data.store_request,
                        rsp_data.slot_used)));
               end
            end
         end
         rsp_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
      end
   end

   initial begin
      int          pool_size;
      int          step_max;
      int          k;
      int          sel;
      bit          hold_time;
      bit          jumpy;
      logic [62:0] wall_time;
      logic [62:0] next_age;
      logic [31:0] peer_ids [64];
      logic [47:0] peer_macs [64];
      req_type     r;

      for (int i = 0; i < ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_node[i] = '0;
         tbl_mac[i] = '0;
         tbl_seen[i] = '0;
      end
      age_limit = '0;
      wall_time = 63'd1000;
      pool_size = 16;
      step_max = 100;
      hold_time = 1'b0;
      jumpy = 1'b0;
      next_age = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_max_age('0);
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_request(DIRECTED[row].req, DIRECTED[row].typed, DIRECTED[row].rsp);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               next_age = TIME_MAX;
               pool_size = 20;
               step_max = 400;
               hold_time = 1'b0;
               jumpy = 1'b0;
               idle_pct = 14;
            end
            1: begin
               next_age = 63'($urandom_range(3000, 200));
               pool_size = 24;
               step_max = 300;
               idle_pct = 0;
            end
            2: begin
               next_age = rand63();
               pool_size = 18;
               step_max = 1 << 20;
               jumpy = 1'b1;
               wall_time = rand63();
               idle_pct = 14;
            end
            3: begin
               next_age = '0;
               pool_size = 40;
               hold_time = 1'b1;
               jumpy = 1'b0;
               wall_time = rand63();
            end
            default: begin
               next_age = 63'($urandom_range(50, 0));
               pool_size = 12;
               step_max = 20;
               hold_time = 1'b0;
            end
         endcase
         set_max_age(next_age);
         for (int i = 0; i < pool_size; i++) begin
            peer_ids[i] = $urandom();
            peer_macs[i] = rand48();
         end

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == PHASES - 1 && n == PHASE_ITEMS / 2) drain_pipeline();
            sel = $urandom_range(99);
            k = $urandom_range(pool_size - 1);
            r.mode = (sel < 45) ? MODE_UPSERT : (sel < 80) ? MODE_RESOLVE :
                     (sel < 94) ? MODE_PURGE : MODE_UNUSED;
            if ($urandom_range(9) == 0) begin
               r.node_id = $urandom();
               r.peer_mac_in = rand48();
            end else begin
               if (r.mode == MODE_UPSERT && $urandom_range(3) == 0) peer_macs[k] = rand48();
               r.node_id = peer_ids[k];
               r.peer_mac_in = peer_macs[k];
            end
            if (!hold_time) begin
               wall_time = wall_time + 63'($urandom_range(step_max));
               if (jumpy && $urandom_range(19) == 0) wall_time = rand63();
            end
            r.now_us = wall_time;
            if (!hold_time && $urandom_range(19) == 0)
               r.now_us = wall_time - 63'($urandom_range(1000));
            send_request(r, CHECK_MODEL, '0);
         end
      end

      drain_pipeline();
      $display("Ran %0d requests over %0d max_age settings: %0d upserts (%0d stores, %0d evictions)",
               n_requests, n_settings, n_upserts, n_stores, n_evictions);
      $display("  %0d resolves (%0d hits), %0d purges (%0d entries dropped), %0d unused mode",
               n_resolves, n_hits, n_purges, n_purged, n_unused);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("peer_address_table_tb OK");
      end else begin
         $display("peer_address_table_tb NOT OK");
      end
      $finish;
   end

endmodule
